/* hdl/sphs_pkg.sv */
// Package for the seeded pointer hash set: payload types and request mode constants.
// Used by the interfaces, the front, the queue, the back, the top level and the checker.
`timescale 1ns / 1ps
package sphs_pkg;
   typedef struct packed {
      logic        mode;
      logic [63:0] key;
   } req_type;

   typedef struct packed {
      logic was_present;
      logic stored;
      logic table_full;
   } rsp_type;

   localparam logic MODE_QUERY  = 1'b0;
   localparam logic MODE_INSERT = 1'b1;
endpackage

/* hdl/sphs_req_if.sv */
// Valid/ready channel that carries one request.
// Depends on sphs_pkg.
`timescale 1ns / 1ps
interface sphs_req_if import sphs_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hdl/sphs_rsp_if.sv */
// Valid/ready channel that carries one result.
// Depends on sphs_pkg.
`timescale 1ns / 1ps
interface sphs_rsp_if import sphs_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hdl/sphs_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sphs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* hdl/sphs_front.sv */
// Front part: accepts requests and hashes the seeded key to a bucket, stage by stage.
// Depends on sphs_pkg; feeds the queue in the top level.
`timescale 1ns / 1ps
module sphs_front import sphs_pkg::*; #(
   parameter int BUCKETS = 1021
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [63:0]                seed,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  req_type                    in_req,
   output logic                       out_valid,
   input  logic                       out_ready,
   output req_type                    out_req,
   output logic [$clog2(BUCKETS)-1:0] out_bucket
);
   localparam int BW = $clog2(BUCKETS);
   localparam logic [63:0]   BMOD = 64'(BUCKETS);
   localparam logic [BW-1:0] FOLD = BW'((2 ** BW) % BUCKETS);

   // Seven mixing steps, then the bits above BW are folded back onto their residue
   // one step per cycle until the value fits, and one compare and subtract ends it.
   logic [3:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] rem_ff, rem_in;
   req_type     req_ff, req_in;
   logic [63:0] fold;

   assign in_ready  = !busy_ff && !done_ff;
   assign out_valid = done_ff;
   assign out_req   = req_ff;
   assign out_bucket = rem_ff[BW-1:0];
   assign fold = ({{BW{1'b0}}, rem_ff[63:BW]} * FOLD) + {{(64-BW){1'b0}}, rem_ff[BW-1:0]};

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      h_in    = h_ff;
      rem_in  = rem_ff;
      req_in  = req_ff;
      if (done_ff && out_ready) begin
         done_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         req_in  = in_req;
         h_in    = in_req.key ^ seed;
         busy_in = 1'b1;
         step_in = 4'd0;
      end else if (busy_ff) begin
         unique case (step_ff)
            4'd0: h_in = (~h_ff) + (h_ff << 21);
            4'd1: h_in = h_ff ^ (h_ff >> 24);
            4'd2: h_in = (h_ff + (h_ff << 3)) + (h_ff << 8);
            4'd3: h_in = h_ff ^ (h_ff >> 14);
            4'd4: h_in = (h_ff + (h_ff << 2)) + (h_ff << 4);
            4'd5: h_in = h_ff ^ (h_ff >> 28);
            4'd6: rem_in = h_ff + (h_ff << 31);
            default: begin
               if (rem_ff[63:BW] != '0) begin
                  rem_in = fold;
               end else begin
                  rem_in  = (rem_ff >= BMOD) ? rem_ff - BMOD : rem_ff;
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         endcase
         if (step_ff != 4'd7) begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      h_ff   <= h_in;
      rem_ff <= rem_in;
      req_ff <= req_in;
   end
endmodule

/* hdl/sphs_queue.sv */
// Two-entry queue between the front and the back parts.
// Depends on sphs_pkg.
`timescale 1ns / 1ps
module sphs_queue import sphs_pkg::*; #(
   parameter int BW = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  req_type       in_req,
   input  logic [BW-1:0] in_bucket,
   output logic          out_valid,
   input  logic          out_ready,
   output req_type       out_req,
   output logic [BW-1:0] out_bucket
);
   req_type       req_ff [2];
   logic [BW-1:0] bkt_ff [2];
   logic          wp_ff, rp_ff;
   logic [1:0]    cnt_ff;
   logic          push, pop;

   assign in_ready   = cnt_ff != 2'd2;
   assign out_valid  = cnt_ff != 2'd0;
   assign out_req    = req_ff[rp_ff];
   assign out_bucket = bkt_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         req_ff[wp_ff] <= in_req;
         bkt_ff[wp_ff] <= in_bucket;
      end
   end
endmodule

/* hdl/sphs_back.sv */
// Back part: clears the head table after reset, walks the bucket chain and pushes new nodes.
// Depends on sphs_pkg and sphs_ram.
`timescale 1ns / 1ps
module sphs_back import sphs_pkg::*; #(
   parameter int BUCKETS = 1021,
   parameter int ENTRIES = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  req_type                    in_req,
   input  logic [$clog2(BUCKETS)-1:0] in_bucket,
   output logic                       out_valid,
   input  logic                       out_ready,
   output rsp_type                    out_rsp
);
   localparam int BW = $clog2(BUCKETS);
   localparam int NW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int HW = NW + 1;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HEAD, S_NODE, S_DONE
   } state_type;

   state_type     state_ff;
   logic [BW-1:0] clr_ff;
   logic [CW-1:0] count_ff;
   req_type       req_ff;
   logic [BW-1:0] bkt_ff;
   logic [HW-1:0] head_ff;
   logic [NW-1:0] node_ff;
   rsp_type       rsp_ff;

   logic          hd_we;
   logic [BW-1:0] hd_wa, hd_ra;
   logic [HW-1:0] hd_wd, hd_rd;
   logic [NW-1:0] nd_ra;
   logic [63:0]   key_rd;
   logic [HW-1:0] link_rd;
   logic [HW-1:0] link_wd;
   logic          nd_ok;

   assign in_ready  = state_ff == S_IDLE;
   assign out_valid = state_ff == S_DONE;
   assign out_rsp   = rsp_ff;

   assign hd_ra = in_bucket;
   assign link_wd = (state_ff == S_HEAD) ? hd_rd : head_ff;

   // Head entry: valid flag on top, node index below.
   sphs_ram #(.WIDTH(HW), .DEPTH(BUCKETS)) u_heads (
      .clock(clock), .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
      .rd_addr(hd_ra), .rd_data(hd_rd)
   );
   sphs_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_keys (
      .clock(clock), .wr_en(hd_we && state_ff != S_CLEAR), .wr_addr(count_ff[NW-1:0]),
      .wr_data(req_ff.key), .rd_addr(nd_ra), .rd_data(key_rd)
   );
   sphs_ram #(.WIDTH(HW), .DEPTH(ENTRIES)) u_links (
      .clock(clock), .wr_en(hd_we && state_ff != S_CLEAR), .wr_addr(count_ff[NW-1:0]),
      .wr_data(link_wd), .rd_addr(nd_ra), .rd_data(link_rd)
   );

   // A node is followed only while the link is valid and below the fill count.
   logic [HW-1:0] nxt;
   assign nxt   = (state_ff == S_HEAD) ? hd_rd : link_rd;
   assign nd_ok = nxt[HW-1] && (CW'(nxt[NW-1:0]) < count_ff);
   assign nd_ra = nxt[NW-1:0];

   logic insert_new;
   assign insert_new = (state_ff == S_NODE) && (key_rd != req_ff.key) && !nd_ok
                       && req_ff.mode == MODE_INSERT && count_ff < CW'(ENTRIES);

   always_comb begin
      hd_we = 1'b0;
      hd_wa = bkt_ff;
      hd_wd = {1'b1, count_ff[NW-1:0]};
      if (state_ff == S_CLEAR) begin
         hd_we = 1'b1;
         hd_wa = clr_ff;
         hd_wd = '0;
      end else if (insert_new || (state_ff == S_HEAD && !nd_ok
                  && req_ff.mode == MODE_INSERT && count_ff < CW'(ENTRIES))) begin
         hd_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               if (clr_ff == BW'(BUCKETS - 1)) state_ff <= S_IDLE;
               clr_ff <= clr_ff + BW'(1);
            end
            S_IDLE: begin
               if (in_valid) begin
                  req_ff   <= in_req;
                  bkt_ff   <= in_bucket;
                  state_ff <= S_HEAD;
               end
            end
            S_HEAD: begin
               head_ff <= hd_rd;
               if (nd_ok) begin
                  state_ff <= S_NODE;
               end else begin
                  rsp_ff.was_present <= 1'b0;
                  rsp_ff.stored      <= 1'b0;
                  rsp_ff.table_full  <= 1'b0;
                  if (req_ff.mode == MODE_INSERT) begin
                     if (count_ff < CW'(ENTRIES)) begin
                        rsp_ff.stored <= 1'b1;
                        count_ff      <= count_ff + CW'(1);
                     end else begin
                        rsp_ff.table_full <= 1'b1;
                     end
                  end
                  state_ff <= S_DONE;
               end
            end
            S_NODE: begin
               if (key_rd == req_ff.key) begin
                  rsp_ff.was_present <= 1'b1;
                  rsp_ff.stored      <= 1'b0;
                  rsp_ff.table_full  <= 1'b0;
                  state_ff <= S_DONE;
               end else if (!nd_ok) begin
                  rsp_ff.was_present <= 1'b0;
                  rsp_ff.stored      <= 1'b0;
                  rsp_ff.table_full  <= 1'b0;
                  if (req_ff.mode == MODE_INSERT) begin
                     if (count_ff < CW'(ENTRIES)) begin
                        rsp_ff.stored <= 1'b1;
                        count_ff      <= count_ff + CW'(1);
                     end else begin
                        rsp_ff.table_full <= 1'b1;
                     end
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* hdl/seeded_pointer_hash_set_top.sv */
// Seeded pointer hash set. A request passes seven hash steps, the remainder folds and a
// final subtract in the front part, then the queue, the head lookup and the walk over
// the chain nodes in the back part.
// The front part takes no new request until the last one is handed on; the queue absorbs back stalls.
// After reset the back part clears every entry of the bucket head table before it takes work.
// Reset is synchronous and active high; the seed resets to zero.
`timescale 1ns / 1ps
module seeded_pointer_hash_set_top import sphs_pkg::*; #(
   parameter int BUCKETS = 1021,
   parameter int ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   sphs_req_if.sink    req,
   sphs_rsp_if.source  rsp
);
   localparam int BW = $clog2(BUCKETS);

   logic [63:0]   seed_ff;
   logic          f_valid, f_ready, q_valid, q_ready;
   req_type       f_req, q_req;
   logic [BW-1:0] f_bkt, q_bkt;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   sphs_front #(.BUCKETS(BUCKETS)) u_front (
      .clock(clock), .reset(reset), .seed(seed_ff),
      .in_valid(req.valid), .in_ready(req.ready), .in_req(req.payload),
      .out_valid(f_valid), .out_ready(f_ready), .out_req(f_req), .out_bucket(f_bkt)
   );
   sphs_queue #(.BW(BW)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_req(f_req), .in_bucket(f_bkt),
      .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req), .out_bucket(q_bkt)
   );
   sphs_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_req(q_req), .in_bucket(q_bkt),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp(rsp.payload)
   );
endmodule

/* hdl/sphs_checker.sv */
// Port checker for the seeded pointer hash set, bound to the top level.
// Depends on sphs_pkg.
`timescale 1ns / 1ps
module sphs_checker import sphs_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);
   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_payload.was_present, rsp_payload.stored,
                              rsp_payload.table_full}))
      else $error("result flags not exclusive");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
endmodule

bind seeded_pointer_hash_set_top sphs_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload)
);
